// ----- rtl/two_class_priority_fifo_defines.svh -----
// Assertion macros for the two-class priority queue checker.
// Depends on nothing; expects clk and rst_n in the scope that uses it.
`ifndef TWO_CLASS_PRIORITY_FIFO_DEFINES_SVH
`define TWO_CLASS_PRIORITY_FIFO_DEFINES_SVH

// Clocked check, muted while reset is asserted.
`define TPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/tpq_pkg.sv -----
// Shared constants and types for the two-class priority queue.
// Depends on nothing; used by the interfaces, the cells, the top level and the checker.
package tpq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int WORD_W         = 32;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int CNT_W_DEF      = 5;

    // request modes
    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PRIO   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEQ    = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // per-cycle command broadcast along the cell row
    typedef struct packed {
        logic insert;   // open a gap at the insert position and load the word there
        logic remove;   // shift every cell one place towards the head
    } tpq_ctrl_t;

endpackage

// ----- rtl/tpq_req_if.sv -----
// Request channel of the two-class priority queue: mode and data word.
// Depends on tpq_pkg.
interface tpq_req_if;
    logic                       valid;
    logic                       ready;
    logic [tpq_pkg::MODE_W-1:0] mode;
    logic [tpq_pkg::WORD_W-1:0] in_word;

    modport source (output valid, output mode, output in_word, input ready);
    modport sink   (input valid, input mode, input in_word, output ready);
endinterface

// ----- rtl/tpq_rsp_if.sv -----
// Result channel of the two-class priority queue: word, status and fill level.
// Depends on tpq_pkg; CNT_W must match the queue's count width.
interface tpq_rsp_if #(
    parameter int CNT_W = tpq_pkg::CNT_W_DEF
);
    logic                         valid;
    logic                         ready;
    logic [tpq_pkg::WORD_W-1:0]   out_word;
    logic                         out_valid;
    logic [tpq_pkg::STATUS_W-1:0] status;
    logic                         now_empty;
    logic [CNT_W-1:0]             held_total;

    modport source (output valid, output out_word, output out_valid, output status,
                    output now_empty, output held_total, input ready);
    modport sink   (input valid, input out_word, input out_valid, input status,
                    input now_empty, input held_total, output ready);
endinterface

// ----- rtl/tpq_cell.sv -----
// One slot of the ordered store: holds a word, takes it from a neighbour or the input.
// Depends on tpq_pkg.
module tpq_cell #(
    parameter int IDX_W = 4,
    parameter int IDX   = 0,
    parameter int W     = 32
) (
    input  logic               clk,
    input  tpq_pkg::tpq_ctrl_t ctrl,
    input  logic [IDX_W-1:0]   pos,
    input  logic [W-1:0]       load_word,
    input  logic [W-1:0]       left_word,
    input  logic [W-1:0]       right_word,
    output logic [W-1:0]       word
);

    localparam logic [IDX_W-1:0] MY_POS = IDX_W'(IDX);

    logic [W-1:0] word_reg;
    logic [W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.remove)
        begin
            word_next = right_word;
        end
        else if (ctrl.insert)
        begin
            if (MY_POS == pos)
            begin
                word_next = load_word;
            end
            else if (MY_POS > pos)
            begin
                word_next = left_word;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ----- rtl/two_class_priority_fifo.sv -----
// Two-class priority queue; a single result register parts the two sides.
// Throughput: one request per cycle while that register is free or being drained.
// Each request is finished in the cycle it is accepted by the row of DEPTH slot cells.
// Reset (rst_n, asynchronous, active low) clears both counts and the result valid flag;
// slot contents are not cleared and are only ever read below the held count.
// Depends on tpq_pkg, tpq_req_if, tpq_rsp_if and tpq_cell.
module two_class_priority_fifo #(
    parameter int DEPTH      = tpq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = tpq_pkg::DATA_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tpq_req_if.sink     req,
    tpq_rsp_if.source   rsp
);

    // Counts must hold DEPTH itself; slot positions need only index the row.
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = $clog2(DEPTH);
    // Words are kept to 32 bits and to DATA_WIDTH, whichever is narrower.
    localparam int STORE_W = (DATA_WIDTH < tpq_pkg::WORD_W) ? DATA_WIDTH : tpq_pkg::WORD_W;

    // Counts: urgent words sit in slots below urgent_reg, normal words up to total_reg.
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_next;
    logic [CNT_W-1:0] urgent_reg;
    logic [CNT_W-1:0] urgent_next;

    // Result register
    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;
    logic [tpq_pkg::WORD_W-1:0]   word_reg;
    logic [tpq_pkg::WORD_W-1:0]   word_next;
    logic                         hit_reg;
    logic                         hit_next;
    logic [tpq_pkg::STATUS_W-1:0] status_reg;
    logic [tpq_pkg::STATUS_W-1:0] status_next;
    logic                         empty_reg;
    logic [CNT_W-1:0]             held_reg;

    logic               req_fire;
    logic               is_enq;
    logic               is_deq;
    logic               full;
    logic               empty;
    tpq_pkg::tpq_ctrl_t ctrl;
    logic [IDX_W-1:0]   pos;
    logic [STORE_W-1:0] load_word;
    logic [STORE_W-1:0] cell_word [DEPTH];

    // Take a new request whenever the result register is free or being drained.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;

    assign is_enq = (req.mode == tpq_pkg::MODE_NORMAL) || (req.mode == tpq_pkg::MODE_PRIO);
    assign is_deq = (req.mode == tpq_pkg::MODE_DEQ);
    assign full   = (total_reg == CNT_W'(DEPTH));
    assign empty  = (total_reg == '0);

    assign ctrl.insert = req_fire && is_enq && !full;
    assign ctrl.remove = req_fire && is_deq && !empty;

    // A priority word goes behind the last urgent word; a normal one at the tail.
    // Both counts stay below DEPTH whenever an insert can happen, so the slice is safe.
    assign pos = (req.mode == tpq_pkg::MODE_PRIO) ? urgent_reg[IDX_W-1:0]
                                                   : total_reg[IDX_W-1:0];
    assign load_word = req.in_word[STORE_W-1:0];

    // Row of slot cells, slot 0 is the head. Each cell sees both neighbours;
    // the ends see their own word, which is never chosen there for a live slot.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [STORE_W-1:0] left_w;
        logic [STORE_W-1:0] right_w;

        if (i == 0)
        begin : g_head
            assign left_w = cell_word[i];
        end
        else
        begin : g_body_l
            assign left_w = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_w = cell_word[i];
        end
        else
        begin : g_body_r
            assign right_w = cell_word[i+1];
        end

        tpq_cell #(
            .IDX_W (IDX_W),
            .IDX   (i),
            .W     (STORE_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .pos        (pos),
            .load_word  (load_word),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[i])
        );
    end

    // Count updates and the result of this request.
    always_comb
    begin
        total_next  = total_reg;
        urgent_next = urgent_reg;
        word_next   = '0;
        hit_next    = 1'b0;
        status_next = tpq_pkg::ST_OK;

        if (ctrl.insert)
        begin
            total_next = total_reg + CNT_W'(1);
            if (req.mode == tpq_pkg::MODE_PRIO)
            begin
                urgent_next = urgent_reg + CNT_W'(1);
            end
        end
        else if (ctrl.remove)
        begin
            total_next = total_reg - CNT_W'(1);
            word_next  = tpq_pkg::WORD_W'(cell_word[0]);
            hit_next   = 1'b1;
            // Drop the priority marker with the word it covered.
            if (urgent_reg != '0)
            begin
                urgent_next = urgent_reg - CNT_W'(1);
            end
        end

        if (is_enq && full)
        begin
            status_next = tpq_pkg::ST_FULL;
        end
        else if (is_deq && empty)
        begin
            status_next = tpq_pkg::ST_EMPTY;
        end
    end

    // Hold the result until taken; refill it on each accepted request.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (req_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            urgent_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            urgent_reg    <= urgent_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            word_reg   <= word_next;
            hit_reg    <= hit_next;
            status_reg <= status_next;
            empty_reg  <= (total_next == '0);
            held_reg   <= total_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.out_word   = word_reg;
    assign rsp.out_valid  = hit_reg;
    assign rsp.status     = status_reg;
    assign rsp.now_empty  = empty_reg;
    assign rsp.held_total = held_reg;

endmodule

// ----- rtl/tpq_checker.sv -----
// Port-level checks for the two-class priority queue, bound to the top level.
// Depends on tpq_pkg and two_class_priority_fifo_defines.svh.
`include "two_class_priority_fifo_defines.svh"

module tpq_checker #(
    parameter int DEPTH = tpq_pkg::DEPTH_DEF,
    parameter int CNT_W = tpq_pkg::CNT_W_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [tpq_pkg::WORD_W-1:0]   out_word,
    input logic                         out_valid,
    input logic [tpq_pkg::STATUS_W-1:0] status,
    input logic                         now_empty,
    input logic [CNT_W-1:0]             held_total
);

    // Every accepted request leaves a result in the next cycle.
    `TPQ_ASSERT(a_req_gives_rsp, req_valid && req_ready |=> rsp_valid, "request lost")

    // The fill level never passes the store size.
    `TPQ_ASSERT(a_held_bound, rsp_valid |-> held_total <= CNT_W'(DEPTH), "held count overflow")

    // Emptiness flag agrees with the count.
    `TPQ_ASSERT(a_empty_match, rsp_valid |-> now_empty == (held_total == '0), "empty flag mismatch")

    // A returned word always comes with an ok status.
    `TPQ_ASSERT(a_hit_ok, rsp_valid && out_valid |-> status == tpq_pkg::ST_OK, "word with error status")

    // A stalled result holds its word.
    `TPQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_word), "result dropped")

endmodule

bind two_class_priority_fifo tpq_checker #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
) u_tpq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .out_word   (rsp.out_word),
    .out_valid  (rsp.out_valid),
    .status     (rsp.status),
    .now_empty  (rsp.now_empty),
    .held_total (rsp.held_total)
);

// ----- tb/tb_top.sv -----
// Self-checking bench for the two-class priority queue: directed cases, a backpressure
// fill, and random request traffic under varying idle and stall rates.
// Depends on tpq_pkg, tpq_req_if, tpq_rsp_if and two_class_priority_fifo.
module tb_top;

    localparam int QDEPTH       = 16;
    localparam int CNT_W        = 5;
    localparam int STALL_LIMIT  = 2000;   // cycles with no handshake on either channel
    localparam int DRAIN_CYCLES = 10;     // settle time once every result is back
    localparam int HOLD_CYCLES  = 80;     // long receiver hold-off in the pressure test
    localparam int REPORT_MAX   = 10;

    // the one mode code the package leaves unnamed
    localparam logic [tpq_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [tpq_pkg::WORD_W-1:0]   word;
        logic                         word_valid;
        logic [tpq_pkg::STATUS_W-1:0] status;
        logic                         now_empty;
        logic [CNT_W-1:0]             count;
    } queue_result_t;

    logic clk = 1'b0;
    logic rst_n;

    tpq_req_if                  req_if();
    tpq_rsp_if #(.CNT_W(CNT_W)) rsp_if();

    two_class_priority_fifo #(
        .DEPTH      (QDEPTH),
        .DATA_WIDTH (tpq_pkg::DATA_WIDTH_DEF)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow of the queue: slot 0 is the head, the first model_urgent slots are the
    // priority class and the rest up to model_total the normal class.
    logic [tpq_pkg::WORD_W-1:0] model_slots [QDEPTH];
    int unsigned                model_total;
    int unsigned                model_urgent;

    // results owed by the block, oldest first
    queue_result_t pending_results [$];

    int src_idle_pct;
    int snk_stall_pct;
    int snk_hold_req;
    int snk_hold_left;
    int mismatch_count;
    int quiet_cycles;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Apply one request to the shadow queue and return the result it must produce.
    function automatic queue_result_t apply_request(
        input logic [tpq_pkg::MODE_W-1:0] mode,
        input logic [tpq_pkg::WORD_W-1:0] word);
        queue_result_t r;
        int unsigned   pos;
        int unsigned   i;
        r = '0;
        r.status = tpq_pkg::ST_OK;
        if (mode == tpq_pkg::MODE_NORMAL || mode == tpq_pkg::MODE_PRIO)
        begin
            if (model_total >= QDEPTH)
                r.status = tpq_pkg::ST_FULL;    // drop the word, nothing moves
            else
            begin
                // a priority word lands behind the other priority words; when the
                // whole queue is priority that is simply the tail
                pos = (mode == tpq_pkg::MODE_PRIO) ? model_urgent : model_total;
                for (i = model_total; i > pos; i--)
                    model_slots[i] = model_slots[i - 1];
                model_slots[pos] = word;
                model_total++;
                if (mode == tpq_pkg::MODE_PRIO)
                    model_urgent++;
            end
        end
        else if (mode == tpq_pkg::MODE_DEQ)
        begin
            if (model_total == 0)
                r.status = tpq_pkg::ST_EMPTY;
            else
            begin
                r.word       = model_slots[0];
                r.word_valid = 1'b1;
                for (i = 1; i < model_total; i++)
                    model_slots[i - 1] = model_slots[i];
                model_total--;
                // a priority head leaves no stale marker behind
                if (model_urgent > 0)
                    model_urgent--;
            end
        end
        r.now_empty = (model_total == 0);
        r.count     = CNT_W'(model_total);
        return r;
    endfunction

    // Mostly random words, with the all-zero and all-one extremes now and then.
    function automatic logic [tpq_pkg::WORD_W-1:0] pick_word();
        logic [tpq_pkg::WORD_W-1:0] w;
        case ($urandom_range(9))
            0:       w = '0;
            1:       w = '1;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Offer one request, called and returning at a falling edge. Valid is left high
    // on return so that back-to-back requests never drop it in between; the next
    // call or the caller lowers it.
    task automatic send_request(input logic [tpq_pkg::MODE_W-1:0] mode,
                                input logic [tpq_pkg::WORD_W-1:0] word);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.mode    <= mode;
        req_if.in_word <= word;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pending_results.push_back(apply_request(mode, word));
        @(negedge clk);
    endtask

    // Hold the request side quiet until every owed result has been taken.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Dequeue and bad-mode on empty, class ordering, priority into an all-priority queue.
    task automatic test_directed_cases();
        int n;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_request(tpq_pkg::MODE_DEQ,    '0);             // dequeue from empty
        send_request(MODE_UNUSED,          32'hDEAD_BEEF);  // unused mode: no change
        send_request(tpq_pkg::MODE_NORMAL, 32'hFFFF_FFFF);
        send_request(tpq_pkg::MODE_PRIO,   32'h0000_0000);  // jumps ahead of the normal word
        send_request(tpq_pkg::MODE_PRIO,   32'h5A5A_5A5A);  // behind the first priority word
        send_request(MODE_UNUSED,          32'h0000_0001);
        send_request(tpq_pkg::MODE_NORMAL, 32'h0000_0001);
        for (n = 0; n < 4; n++)
            send_request(tpq_pkg::MODE_DEQ, 32'hFFFF_FFFF);
        send_request(tpq_pkg::MODE_DEQ, '0);                // empty again
        // every held word priority: the new one goes to the tail
        send_request(tpq_pkg::MODE_PRIO,   32'hA5A5_A5A5);
        send_request(tpq_pkg::MODE_PRIO,   32'h8000_0000);
        send_request(tpq_pkg::MODE_PRIO,   32'h7FFF_FFFF);
        send_request(tpq_pkg::MODE_NORMAL, 32'h1234_5678);
        send_request(tpq_pkg::MODE_PRIO,   32'hFEDC_BA98);
        for (n = 0; n < 5; n++)
            send_request(tpq_pkg::MODE_DEQ, '0);
        wait_drained();
    endtask

    // Stall the receiver for a long stretch while requests fill past full, so the
    // result register blocks the input; then drain past empty.
    task automatic test_backpressure();
        int n;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        snk_hold_req  = HOLD_CYCLES;
        for (n = 0; n < QDEPTH + 2; n++)
            send_request(n[0] ? tpq_pkg::MODE_PRIO : tpq_pkg::MODE_NORMAL, pick_word());
        // pause the sender until the block has caught up
        wait_drained();
        for (n = 0; n < QDEPTH + 1; n++)
            send_request(tpq_pkg::MODE_DEQ, pick_word());
        wait_drained();
    endtask

    // Random traffic in bursts that lean towards filling or draining, so the queue
    // swings between empty and full rather than hovering near one level.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        int                         n;
        int                         burst_left;
        int                         roll;
        bit                         filling;
        logic [tpq_pkg::MODE_W-1:0] mode;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        burst_left    = 0;
        filling       = 1'b1;
        for (n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                filling    = 1'($urandom_range(1));
                burst_left = $urandom_range(40, 8);
            end
            burst_left--;
            roll = $urandom_range(99);
            if (roll < 3)
                mode = MODE_UNUSED;
            else if ((roll < 75) == filling)
                mode = $urandom_range(1) ? tpq_pkg::MODE_PRIO : tpq_pkg::MODE_NORMAL;
            else
                mode = tpq_pkg::MODE_DEQ;
            send_request(mode, pick_word());
        end
        wait_drained();
    endtask

    // Receiver: random stalls, overridden by a requested hold-off counted here.
    always @(negedge clk)
    begin
        if (snk_hold_req != 0)
        begin
            snk_hold_left = snk_hold_req;
            snk_hold_req  = 0;
        end
        if (snk_hold_left != 0)
        begin
            rsp_if.ready <= 1'b0;
            snk_hold_left--;
        end
        else
            rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Compare each taken result with the oldest owed one.
    always @(posedge clk)
    begin : check_results
        queue_result_t got;
        queue_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = '{rsp_if.out_word, rsp_if.out_valid, rsp_if.status,
                    rsp_if.now_empty, rsp_if.held_total};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: word %h valid %0d st %0d empty %0d count %0d",
                             got.word, got.word_valid, got.status, got.now_empty, got.count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.word !== want.word || got.word_valid !== want.word_valid ||
                    got.status !== want.status || got.now_empty !== want.now_empty ||
                    got.count !== want.count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("mismatch: exp word %h valid %0d st %0d empty %0d count %0d",
                                 want.word, want.word_valid, want.status, want.now_empty,
                                 want.count);
                        $display("          got word %h valid %0d st %0d empty %0d count %0d",
                                 got.word, got.word_valid, got.status, got.now_empty,
                                 got.count);
                    end
                end
            end
        end
    end

    // Watchdog: give up once neither channel has moved for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.mode    = tpq_pkg::MODE_NORMAL;
        req_if.in_word = '0;
        rsp_if.ready   = 1'b0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        snk_hold_req   = 0;
        snk_hold_left  = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        model_total    = 0;
        model_urgent   = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_backpressure();
        test_random_traffic(0,  0,  370);
        test_random_traffic(46, 0,  370);
        test_random_traffic(0,  46, 370);
        test_random_traffic(27, 27, 370);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
